FILE: rtl/assert_macros.svh
// Assertion helpers, reset-aware.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rls_pkg.sv
package rls_pkg;

  localparam int MAX_TEXT = 4095;
  localparam int MAX_NEST = 255;

  // position counts up to MAX_TEXT + 1
  localparam int POS_W   = $clog2(MAX_TEXT + 2);
  localparam int DEPTH_W = $clog2(MAX_NEST + 1);
  localparam int LEN_W   = 12;
  localparam int NFLAG   = 6;
  localparam int OUT_W   = 32;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_G         = 8'h67;
  localparam logic [7:0] CH_I         = 8'h69;
  localparam logic [7:0] CH_M         = 8'h6D;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_S         = 8'h73;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic             emit;
    logic             valid_res;
    logic [LEN_W-1:0] pattern_length;
    logic [LEN_W-1:0] consumed_length;
    logic [NFLAG-1:0] flags;   // bit 0 g, 1 i, 2 m, 3 u, 4 x, 5 s
  } rls_res_t;

  // One-hot flag mask for a flag letter, zero for anything else.
  function automatic logic [NFLAG-1:0] flag_mask(input logic [7:0] c);
    logic [NFLAG-1:0] m;
    m = '0;
    case (c)
      CH_G:    m = 6'b000001;
      CH_I:    m = 6'b000010;
      CH_M:    m = 6'b000100;
      CH_U:    m = 6'b001000;
      CH_X:    m = 6'b010000;
      CH_S:    m = 6'b100000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/rls_in_stage.sv
module rls_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rls_pkg::in_item_t in_item,
  input  logic              take,      // scan consumes the held byte this cycle
  output logic              item_valid,
  output rls_pkg::in_item_t item
);

  logic              valid_r;
  rls_pkg::in_item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: rtl/rls_scan.sv
`include "assert_macros.svh"

module rls_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  rls_pkg::in_item_t item,
  output rls_pkg::rls_res_t res
);

  typedef enum logic [1:0] {
    PH_DONE    = 2'd0,
    PH_PATTERN = 2'd1,
    PH_FLAGS   = 2'd2
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic                                esc_r, esc_nxt;
  logic [rls_pkg::DEPTH_W-1:0]         depth_r, depth_nxt;
  logic [rls_pkg::POS_W-1:0]           pos_r, pos_nxt;
  logic [rls_pkg::POS_W-1:0]           psize_r, psize_nxt;
  logic [rls_pkg::NFLAG-1:0]           flags_r, flags_nxt;
  logic [rls_pkg::NFLAG-1:0]           mask;
  logic [rls_pkg::POS_W-1:0]           psize_new;
  logic                                over_limit;

  assign mask       = rls_pkg::flag_mask(item.ch);
  assign psize_new  = pos_r - rls_pkg::POS_W'(1);
  assign over_limit = pos_r > rls_pkg::POS_W'(rls_pkg::MAX_TEXT);

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    depth_nxt = depth_r;
    pos_nxt   = pos_r;
    psize_nxt = psize_r;
    flags_nxt = flags_r;
    res       = '0;

    if (item.start_req) begin
      esc_nxt   = 1'b0;
      depth_nxt = '0;
      psize_nxt = '0;
      flags_nxt = '0;
      pos_nxt   = rls_pkg::POS_W'(1);
      if (item.ch != rls_pkg::CH_SLASH) begin
        res.emit  = 1'b1;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_PATTERN;
      end
    end else if (phase_r == PH_PATTERN || phase_r == PH_FLAGS) begin
      if (over_limit) begin
        res.emit  = 1'b1;
        phase_nxt = PH_DONE;
      end else begin
        pos_nxt = pos_r + rls_pkg::POS_W'(1);
        case (phase_r)
          PH_PATTERN: begin
            if (item.ch == rls_pkg::CH_NUL) begin
              res.emit  = 1'b1;
              phase_nxt = PH_DONE;
            end else if (esc_r) begin
              esc_nxt = 1'b0;
            end else if (item.ch == rls_pkg::CH_SLASH && depth_r == '0) begin
              psize_nxt = psize_new;
              if (psize_new == '0) begin
                res.emit  = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_FLAGS;
              end
            end else if (item.ch == rls_pkg::CH_LBRACKET) begin
              if (depth_r != rls_pkg::DEPTH_W'(rls_pkg::MAX_NEST)) begin
                depth_nxt = depth_r + rls_pkg::DEPTH_W'(1);
              end
            end else if (item.ch == rls_pkg::CH_RBRACKET) begin
              if (depth_r != '0) begin
                depth_nxt = depth_r - rls_pkg::DEPTH_W'(1);
              end
            end else if (item.ch == rls_pkg::CH_BACKSLASH) begin
              esc_nxt = 1'b1;
            end
          end
          default: begin
            // flag letters; unknown or repeated letter closes the literal
            if (mask == '0 || (flags_r & mask) != '0) begin
              res.emit            = 1'b1;
              res.valid_res       = 1'b1;
              res.pattern_length  = rls_pkg::LEN_W'(psize_r);
              res.consumed_length = rls_pkg::LEN_W'(pos_r);
              res.flags           = flags_r;
              phase_nxt           = PH_DONE;
            end else begin
              flags_nxt = flags_r | mask;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      esc_r   <= 1'b0;
      depth_r <= '0;
      pos_r   <= '0;
      psize_r <= '0;
      flags_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      psize_r <= psize_nxt;
      flags_r <= flags_nxt;
    end
  end

  `ASSERT_ALWAYS(a_pos_bound, clk, rst_n,
    pos_r <= rls_pkg::POS_W'(rls_pkg::MAX_TEXT + 1), "position past limit")
  `ASSERT_ALWAYS(a_depth_bound, clk, rst_n,
    depth_r <= rls_pkg::DEPTH_W'(rls_pkg::MAX_NEST), "bracket depth past limit")
  `ASSERT_NEXT(a_emit_done, clk, rst_n,
    step_en && res.emit, phase_r == PH_DONE, "scan not closed after result")
  `ASSERT_NEXT(a_hold, clk, rst_n,
    !step_en, $stable({phase_r, pos_r, flags_r}), "state moved while stalled")
  `ASSERT_ALWAYS(a_flags_phase, clk, rst_n,
    flags_r == '0 || phase_r != PH_PATTERN, "flags set during pattern scan")

endmodule

FILE: rtl/rls_out_stage.sv
module rls_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,    // new result from the scan
  input  rls_pkg::rls_res_t           res,
  output logic                        free,    // register can take a result
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rls_pkg::OUT_W-1:0]   out_tdata
);

  logic                        valid_r;
  logic [rls_pkg::OUT_W-1:0]   data_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= {1'b0, res.flags, res.consumed_length, res.pattern_length, res.valid_res};
    end
  end

endmodule

FILE: rtl/regex_literal_scanner_core.sv
// Path: the byte that closes the scan is held in the input register, then its result is
//   loaded into the result register, which raises out_tvalid; the scan waits while that is full.
// Throughput: one byte per cycle while the result register is free to take a result.
// Reset: rst_n is synchronous, active low; it empties both stages and returns the scan to
//   done, so bytes without in_tuser set are dropped until a new literal starts.
module regex_literal_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel: one byte of literal text per transfer
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] start_req
  // result channel: one transfer per finished scan
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [0] valid_res, [12:1] pattern_length,
                                  // [24:13] consumed_length, [25] flag_global,
                                  // [26] flag_ignore_case, [27] flag_multiline,
                                  // [28] flag_unicode, [29] flag_extended,
                                  // [30] flag_dotall, [31] zero
);

  rls_pkg::in_item_t in_item;
  rls_pkg::in_item_t item;
  rls_pkg::rls_res_t res;
  logic              item_valid;
  logic              out_free;
  logic              step_en;

  assign in_item.ch        = in_tdata;
  assign in_item.start_req = in_tuser;

  // The held byte is processed only when the result register can take
  // whatever it produces; a stalled output freezes the scan state.
  assign step_en = item_valid && out_free;

  rls_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (step_en),
    .item_valid (item_valid),
    .item       (item)
  );

  rls_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item),
    .res     (res)
  );

  rls_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en && res.emit),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
